// File: design/dpb_pkg.sv
// Shared constants, configuration struct and reciprocal table for the
// depth pixel back-projection pipeline. No dependencies.
package dpb_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int RGB_W      = 3 * COLOR_W;
    localparam int Z_W        = 20;
    localparam int PT_W       = 25;
    localparam int CENTER_W   = 16;
    localparam int INV_W      = 24;
    localparam int INV_HALF_W = 12;
    localparam int SCALE_W    = 5;
    localparam int SUBPIX_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Reciprocal of the scale, ceil(2^RECIP_SHIFT / s), exact for 16-bit coordinates
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP_W     = 22;

    // Depth conversion: z = (depth * 10 * 65536 + 32767) / 65535
    localparam int DEPTH_FULL = 65535;
    localparam int Z_HALF     = 32767;

    // Projection rounding and saturation
    localparam int PROJ_SHIFT  = 16;
    localparam int ROUND_BIAS  = 134217728;
    localparam int SAT_POS_MAG = 16777215;
    localparam int SAT_NEG_MAG = 16777216;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y = 3'd5;

    // Reset values
    localparam logic [SCALE_W-1:0]  RST_SCALE       = 5'd1;
    localparam logic                RST_COLOR_MODE  = 1'b0;
    localparam logic [CENTER_W-1:0] RST_CENTER_X    = 16'd5112;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 16'd3832;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_X = 24'd31957;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y = 24'd31957;

    // scale holds the effective step: a written zero is seen as one
    typedef struct packed {
        logic [SCALE_W-1:0]  scale;
        logic                color_mode;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
    } cfg_t;

    function automatic int mag_width(input int coord_bits);
        return (coord_bits + SUBPIX_W > CENTER_W) ? coord_bits + SUBPIX_W : CENTER_W;
    endfunction

    function automatic logic [RECIP_W-1:0] recip(input logic [SCALE_W-1:0] s);
        logic [RECIP_W-1:0] m;
        case (s)
            5'd2:    m = 22'd1048576;
            5'd3:    m = 22'd699051;
            5'd4:    m = 22'd524288;
            5'd5:    m = 22'd419431;
            5'd6:    m = 22'd349526;
            5'd7:    m = 22'd299594;
            5'd8:    m = 22'd262144;
            5'd9:    m = 22'd233017;
            5'd10:   m = 22'd209716;
            5'd11:   m = 22'd190651;
            5'd12:   m = 22'd174763;
            5'd13:   m = 22'd161320;
            5'd14:   m = 22'd149797;
            5'd15:   m = 22'd139811;
            5'd16:   m = 22'd131072;
            5'd17:   m = 22'd123362;
            5'd18:   m = 22'd116509;
            5'd19:   m = 22'd110377;
            5'd20:   m = 22'd104858;
            5'd21:   m = 22'd99865;
            5'd22:   m = 22'd95326;
            5'd23:   m = 22'd91181;
            5'd24:   m = 22'd87382;
            5'd25:   m = 22'd83887;
            5'd26:   m = 22'd80660;
            5'd27:   m = 22'd77673;
            5'd28:   m = 22'd74899;
            5'd29:   m = 22'd72316;
            5'd30:   m = 22'd69906;
            5'd31:   m = 22'd67651;
            default: m = 22'd2097152;
        endcase
        return m;
    endfunction

endpackage

// File: design/dpb_front.sv
// First pipeline stage: depth to meters, offsets from the principal point,
// grid quotient by reciprocal multiply. Depends on dpb_pkg.
module dpb_front #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  dpb_pkg::cfg_t                                cfg,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [dpb_pkg::DEPTH_W-1:0]                  depth,
    input  logic [COORD_BITS-1:0]                        pixel_col,
    input  logic [COORD_BITS-1:0]                        pixel_row,
    input  logic [dpb_pkg::RGB_W-1:0]                    rgb_in,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [dpb_pkg::Z_W-1:0]                      z,
    output logic [dpb_pkg::mag_width(COORD_BITS)-1:0]    mag_x,
    output logic                                         neg_x,
    output logic [dpb_pkg::mag_width(COORD_BITS)-1:0]    mag_y,
    output logic                                         neg_y,
    output logic [COORD_BITS-1:0]                        quot_col,
    output logic [COORD_BITS-1:0]                        quot_row,
    output logic [COORD_BITS-1:0]                        col,
    output logic [COORD_BITS-1:0]                        row,
    output logic [dpb_pkg::RGB_W-1:0]                    rgb
);
    import dpb_pkg::*;

    localparam int MAG_W  = mag_width(COORD_BITS);
    localparam int POS_W  = COORD_BITS + SUBPIX_W;
    localparam int PROD_W = COORD_BITS + RECIP_W;

    logic [Z_W-1:0]       d10;
    logic [Z_W-1:0]       biased;
    logic [DEPTH_W:0]     fold_sum;
    logic [Z_W-1:0]       z_next;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [MAG_W-1:0]     px, py, cx, cy;
    logic                 neg_x_next, neg_y_next;
    logic [MAG_W-1:0]     mag_x_next, mag_y_next;
    logic [RECIP_W-1:0]   recip_s;
    logic [PROD_W-1:0]    col_prod, row_prod;
    logic [RGB_W-1:0]     rgb_next;

    logic                 valid_reg;
    logic [Z_W-1:0]       z_reg;
    logic [MAG_W-1:0]     mag_x_reg, mag_y_reg;
    logic                 neg_x_reg, neg_y_reg;
    logic [COORD_BITS-1:0] quot_col_reg, quot_row_reg, col_reg, row_reg;
    logic [RGB_W-1:0]     rgb_reg;

    // Split depth*10*65536 into depth*10*65535 + depth*10; the remainder
    // divide by 65535 then folds to one compare.
    always_comb
    begin
        d10      = Z_W'({depth, 3'b000}) + Z_W'({depth, 1'b0});
        biased   = d10 + Z_W'(Z_HALF);
        fold_sum = (DEPTH_W + 1)'(biased[Z_W-1:DEPTH_W]) + (DEPTH_W + 1)'(biased[DEPTH_W-1:0]);
        z_next   = d10 + Z_W'(biased[Z_W-1:DEPTH_W])
                 + Z_W'(fold_sum >= (DEPTH_W + 1)'(DEPTH_FULL));
    end

    always_comb
    begin
        pos_x      = {pixel_col, {SUBPIX_W{1'b0}}};
        pos_y      = {pixel_row, {SUBPIX_W{1'b0}}};
        px         = MAG_W'(pos_x);
        py         = MAG_W'(pos_y);
        cx         = MAG_W'(cfg.center_x);
        cy         = MAG_W'(cfg.center_y);
        neg_x_next = px < cx;
        neg_y_next = py < cy;
        mag_x_next = neg_x_next ? (cx - px) : (px - cx);
        mag_y_next = neg_y_next ? (cy - py) : (py - cy);
    end

    always_comb
    begin
        recip_s  = recip(cfg.scale);
        col_prod = PROD_W'(pixel_col) * PROD_W'(recip_s);
        row_prod = PROD_W'(pixel_row) * PROD_W'(recip_s);
        rgb_next = cfg.color_mode ? rgb_in : '0;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            z_reg        <= z_next;
            mag_x_reg    <= mag_x_next;
            mag_y_reg    <= mag_y_next;
            neg_x_reg    <= neg_x_next;
            neg_y_reg    <= neg_y_next;
            quot_col_reg <= col_prod[RECIP_SHIFT +: COORD_BITS];
            quot_row_reg <= row_prod[RECIP_SHIFT +: COORD_BITS];
            col_reg      <= pixel_col;
            row_reg      <= pixel_row;
            rgb_reg      <= rgb_next;
        end
    end

    assign out_valid = valid_reg;
    assign z         = z_reg;
    assign mag_x     = mag_x_reg;
    assign mag_y     = mag_y_reg;
    assign neg_x     = neg_x_reg;
    assign neg_y     = neg_y_reg;
    assign quot_col  = quot_col_reg;
    assign quot_row  = quot_row_reg;
    assign col       = col_reg;
    assign row       = row_reg;
    assign rgb       = rgb_reg;

endmodule

// File: design/dpb_mul.sv
// Second and third pipeline stages: grid check and drop, depth times offset,
// then the split product with the reciprocal focal length. Depends on dpb_pkg.
module dpb_mul #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  dpb_pkg::cfg_t                                cfg,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [dpb_pkg::Z_W-1:0]                      z_in,
    input  logic [dpb_pkg::mag_width(COORD_BITS)-1:0]    mag_x,
    input  logic                                         neg_x_in,
    input  logic [dpb_pkg::mag_width(COORD_BITS)-1:0]    mag_y,
    input  logic                                         neg_y_in,
    input  logic [COORD_BITS-1:0]                        quot_col,
    input  logic [COORD_BITS-1:0]                        quot_row,
    input  logic [COORD_BITS-1:0]                        col,
    input  logic [COORD_BITS-1:0]                        row,
    input  logic [dpb_pkg::RGB_W-1:0]                    rgb_in,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [dpb_pkg::Z_W + dpb_pkg::mag_width(COORD_BITS)
                  + dpb_pkg::INV_HALF_W - 1:0]           hi_x,
    output logic [dpb_pkg::Z_W + dpb_pkg::mag_width(COORD_BITS)
                  + dpb_pkg::INV_HALF_W - 1:0]           lo_x,
    output logic [dpb_pkg::Z_W + dpb_pkg::mag_width(COORD_BITS)
                  + dpb_pkg::INV_HALF_W - 1:0]           hi_y,
    output logic [dpb_pkg::Z_W + dpb_pkg::mag_width(COORD_BITS)
                  + dpb_pkg::INV_HALF_W - 1:0]           lo_y,
    output logic                                         neg_x,
    output logic                                         neg_y,
    output logic [dpb_pkg::Z_W-1:0]                      z,
    output logic [COORD_BITS-1:0]                        grid_col,
    output logic [COORD_BITS-1:0]                        grid_row,
    output logic [dpb_pkg::RGB_W-1:0]                    rgb
);
    import dpb_pkg::*;

    localparam int MAG_W = mag_width(COORD_BITS);
    localparam int M1_W  = Z_W + MAG_W;
    localparam int P_W   = M1_W + INV_HALF_W;
    localparam int QS_W  = COORD_BITS + SCALE_W;

    logic [QS_W-1:0]       back_col, back_row;
    logic                  keep;
    logic                  s3_ready;

    logic                  s2_valid_reg;
    logic [M1_W-1:0]       m1_x_reg, m1_y_reg;
    logic                  s2_neg_x_reg, s2_neg_y_reg;
    logic [Z_W-1:0]        s2_z_reg;
    logic [COORD_BITS-1:0] s2_col_reg, s2_row_reg;
    logic [RGB_W-1:0]      s2_rgb_reg;

    logic                  s3_valid_reg;
    logic [P_W-1:0]        hi_x_reg, lo_x_reg, hi_y_reg, lo_y_reg;
    logic                  s3_neg_x_reg, s3_neg_y_reg;
    logic [Z_W-1:0]        s3_z_reg;
    logic [COORD_BITS-1:0] s3_col_reg, s3_row_reg;
    logic [RGB_W-1:0]      s3_rgb_reg;

    // Drop off-grid pixels and, in color mode, zero depth
    always_comb
    begin
        back_col = QS_W'(quot_col) * QS_W'(cfg.scale);
        back_row = QS_W'(quot_row) * QS_W'(cfg.scale);
        keep     = (back_col == QS_W'(col)) && (back_row == QS_W'(row))
                && !(cfg.color_mode && (z_in == '0));
    end

    assign in_ready = !s2_valid_reg || s3_ready;
    assign s3_ready = !s3_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s2_valid_reg <= in_valid && keep;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            m1_x_reg     <= M1_W'(z_in) * M1_W'(mag_x);
            m1_y_reg     <= M1_W'(z_in) * M1_W'(mag_y);
            s2_neg_x_reg <= neg_x_in;
            s2_neg_y_reg <= neg_y_in;
            s2_z_reg     <= z_in;
            s2_col_reg   <= quot_col;
            s2_row_reg   <= quot_row;
            s2_rgb_reg   <= rgb_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            hi_x_reg     <= P_W'(m1_x_reg) * P_W'(cfg.inv_focal_x[INV_W-1:INV_HALF_W]);
            lo_x_reg     <= P_W'(m1_x_reg) * P_W'(cfg.inv_focal_x[INV_HALF_W-1:0]);
            hi_y_reg     <= P_W'(m1_y_reg) * P_W'(cfg.inv_focal_y[INV_W-1:INV_HALF_W]);
            lo_y_reg     <= P_W'(m1_y_reg) * P_W'(cfg.inv_focal_y[INV_HALF_W-1:0]);
            s3_neg_x_reg <= s2_neg_x_reg;
            s3_neg_y_reg <= s2_neg_y_reg;
            s3_z_reg     <= s2_z_reg;
            s3_col_reg   <= s2_col_reg;
            s3_row_reg   <= s2_row_reg;
            s3_rgb_reg   <= s2_rgb_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign hi_x      = hi_x_reg;
    assign lo_x      = lo_x_reg;
    assign hi_y      = hi_y_reg;
    assign lo_y      = lo_y_reg;
    assign neg_x     = s3_neg_x_reg;
    assign neg_y     = s3_neg_y_reg;
    assign z         = s3_z_reg;
    assign grid_col  = s3_col_reg;
    assign grid_row  = s3_row_reg;
    assign rgb       = s3_rgb_reg;

endmodule

// File: design/dpb_out.sv
// Last pipeline stage: join the partial products, round, saturate and hold
// the finished point in the output register. Depends on dpb_pkg.
module dpb_out #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [dpb_pkg::Z_W + dpb_pkg::mag_width(COORD_BITS)
                  + dpb_pkg::INV_HALF_W - 1:0]           hi_x,
    input  logic [dpb_pkg::Z_W + dpb_pkg::mag_width(COORD_BITS)
                  + dpb_pkg::INV_HALF_W - 1:0]           lo_x,
    input  logic [dpb_pkg::Z_W + dpb_pkg::mag_width(COORD_BITS)
                  + dpb_pkg::INV_HALF_W - 1:0]           hi_y,
    input  logic [dpb_pkg::Z_W + dpb_pkg::mag_width(COORD_BITS)
                  + dpb_pkg::INV_HALF_W - 1:0]           lo_y,
    input  logic                                         neg_x,
    input  logic                                         neg_y,
    input  logic [dpb_pkg::Z_W-1:0]                      z_in,
    input  logic [COORD_BITS-1:0]                        grid_col_in,
    input  logic [COORD_BITS-1:0]                        grid_row_in,
    input  logic [dpb_pkg::RGB_W-1:0]                    rgb_in,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [dpb_pkg::PT_W-1:0]                     point_x,
    output logic [dpb_pkg::PT_W-1:0]                     point_y,
    output logic [dpb_pkg::Z_W-1:0]                      point_z,
    output logic [COORD_BITS-1:0]                        grid_col,
    output logic [COORD_BITS-1:0]                        grid_row,
    output logic [dpb_pkg::RGB_W-1:0]                    rgb
);
    import dpb_pkg::*;

    localparam int P_W = Z_W + mag_width(COORD_BITS) + INV_HALF_W;
    localparam int T_W = P_W + 1;
    localparam int R_W = T_W - PROJ_SHIFT;

    // (hi*2^12 + lo + 2^27) >> 28, then sign and clamp
    function automatic logic [PT_W-1:0] round_sat(input logic [P_W-1:0] hi,
                                                  input logic [P_W-1:0] lo,
                                                  input logic           neg);
        logic [T_W-1:0]  t;
        logic [T_W-1:0]  s;
        logic [R_W-1:0]  r;
        logic [PT_W-1:0] res;
        t = T_W'(lo) + T_W'(ROUND_BIAS);
        s = T_W'(hi) + (t >> INV_HALF_W);
        r = s[T_W-1:PROJ_SHIFT];
        if (neg)
        begin
            if (r > R_W'(SAT_NEG_MAG))
                res = {1'b1, {(PT_W - 1){1'b0}}};
            else
                res = PT_W'(0) - r[PT_W-1:0];
        end
        else
        begin
            if (r > R_W'(SAT_POS_MAG))
                res = {1'b0, {(PT_W - 1){1'b1}}};
            else
                res = r[PT_W-1:0];
        end
        return res;
    endfunction

    logic                  valid_reg;
    logic [PT_W-1:0]       x_reg, y_reg;
    logic [Z_W-1:0]        z_reg;
    logic [COORD_BITS-1:0] col_reg, row_reg;
    logic [RGB_W-1:0]      rgb_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg   <= round_sat(hi_x, lo_x, neg_x);
            y_reg   <= round_sat(hi_y, lo_y, neg_y);
            z_reg   <= z_in;
            col_reg <= grid_col_in;
            row_reg <= grid_row_in;
            rgb_reg <= rgb_in;
        end
    end

    assign out_valid = valid_reg;
    assign point_x   = x_reg;
    assign point_y   = y_reg;
    assign point_z   = z_reg;
    assign grid_col  = col_reg;
    assign grid_row  = row_reg;
    assign rgb       = rgb_reg;

endmodule

// File: design/depth_pixel_backprojection.sv
// Top level of the depth pixel back-projection pipeline: configuration
// registers, stream ports and the stage chain. Depends on dpb_pkg, dpb_front,
// dpb_mul and dpb_out.
//
//  channel    direction  handshake                      payload
//  ---------  ---------  -----------------------------  ---------------------------------
//  cfg        in         cfg_valid / cfg_ready          cfg_index, cfg_data
//  s_axis     in         s_axis_tvalid / s_axis_tready  depth pixel with column, row, RGB
//  m_axis     out        m_axis_tvalid / m_axis_tready  3-D point, grid position, RGB
//
// One pixel request is taken every cycle while m_axis is not stalled; a kept pixel
// passes four register stages (front stage, grid check and depth product, focal
// product, round and output register) before it shows up on m_axis. Dropped pixels
// leave a bubble. Reset clears the stage valid bits and loads the register defaults;
// there is no clearing pass. A stall on m_axis holds every full stage and backs up
// to s_axis_tready through the ready chain; nothing is lost or repeated.
// cfg_ready is always high.
module depth_pixel_backprojection #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]       cfg_data,
    // pixel requests
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata, low bit up: depth, pixel_col, pixel_row, red_in, green_in, blue_in, zero pad
    input  logic [((dpb_pkg::DEPTH_W + 2 * COORD_BITS + dpb_pkg::RGB_W + 7) / 8) * 8 - 1:0]
                                                 s_axis_tdata,
    // point results
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata, low bit up: point_x, point_y, point_z, grid_col, grid_row,
    // red_out, green_out, blue_out, zero pad
    output logic [((2 * dpb_pkg::PT_W + dpb_pkg::Z_W + 2 * COORD_BITS + dpb_pkg::RGB_W + 7)
                   / 8) * 8 - 1:0]               m_axis_tdata
);
    import dpb_pkg::*;

    localparam int MAG_W   = mag_width(COORD_BITS);
    localparam int P_W     = Z_W + MAG_W + INV_HALF_W;
    localparam int OFF_COL = DEPTH_W;
    localparam int OFF_ROW = DEPTH_W + COORD_BITS;
    localparam int OFF_RGB = DEPTH_W + 2 * COORD_BITS;
    localparam int OUT_W   = ((2 * PT_W + Z_W + 2 * COORD_BITS + RGB_W + 7) / 8) * 8;

    // Configuration registers
    logic [SCALE_W-1:0]  scale_reg;
    logic                color_mode_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [INV_W-1:0]    inv_focal_x_reg;
    logic [INV_W-1:0]    inv_focal_y_reg;
    cfg_t                cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg       <= RST_SCALE;
            color_mode_reg  <= RST_COLOR_MODE;
            center_x_reg    <= RST_CENTER_X;
            center_y_reg    <= RST_CENTER_Y;
            inv_focal_x_reg <= RST_INV_FOCAL_X;
            inv_focal_y_reg <= RST_INV_FOCAL_Y;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SCALE:       scale_reg       <= cfg_data[SCALE_W-1:0];
                CFG_COLOR_MODE:  color_mode_reg  <= cfg_data[0];
                CFG_CENTER_X:    center_x_reg    <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:    center_y_reg    <= cfg_data[CENTER_W-1:0];
                CFG_INV_FOCAL_X: inv_focal_x_reg <= cfg_data[INV_W-1:0];
                CFG_INV_FOCAL_Y: inv_focal_y_reg <= cfg_data[INV_W-1:0];
                default:         ; // drop writes to unknown indexes
            endcase
        end
    end

    // A scale of zero steps by one pixel
    always_comb
    begin
        cfg.scale       = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
        cfg.color_mode  = color_mode_reg;
        cfg.center_x    = center_x_reg;
        cfg.center_y    = center_y_reg;
        cfg.inv_focal_x = inv_focal_x_reg;
        cfg.inv_focal_y = inv_focal_y_reg;
    end

    // Front stage -> multiply stages
    logic                  f_valid, f_ready;
    logic [Z_W-1:0]        f_z;
    logic [MAG_W-1:0]      f_mag_x, f_mag_y;
    logic                  f_neg_x, f_neg_y;
    logic [COORD_BITS-1:0] f_quot_col, f_quot_row, f_col, f_row;
    logic [RGB_W-1:0]      f_rgb;

    // Multiply stages -> output stage
    logic                  m_valid, m_ready;
    logic [P_W-1:0]        m_hi_x, m_lo_x, m_hi_y, m_lo_y;
    logic                  m_neg_x, m_neg_y;
    logic [Z_W-1:0]        m_z;
    logic [COORD_BITS-1:0] m_grid_col, m_grid_row;
    logic [RGB_W-1:0]      m_rgb;

    // Finished point
    logic [PT_W-1:0]       point_x, point_y;
    logic [Z_W-1:0]        point_z;
    logic [COORD_BITS-1:0] grid_col, grid_row;
    logic [RGB_W-1:0]      rgb_out;

    dpb_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .depth     (s_axis_tdata[DEPTH_W-1:0]),
        .pixel_col (s_axis_tdata[OFF_COL +: COORD_BITS]),
        .pixel_row (s_axis_tdata[OFF_ROW +: COORD_BITS]),
        .rgb_in    (s_axis_tdata[OFF_RGB +: RGB_W]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .z         (f_z),
        .mag_x     (f_mag_x),
        .neg_x     (f_neg_x),
        .mag_y     (f_mag_y),
        .neg_y     (f_neg_y),
        .quot_col  (f_quot_col),
        .quot_row  (f_quot_row),
        .col       (f_col),
        .row       (f_row),
        .rgb       (f_rgb)
    );

    dpb_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .z_in      (f_z),
        .mag_x     (f_mag_x),
        .neg_x_in  (f_neg_x),
        .mag_y     (f_mag_y),
        .neg_y_in  (f_neg_y),
        .quot_col  (f_quot_col),
        .quot_row  (f_quot_row),
        .col       (f_col),
        .row       (f_row),
        .rgb_in    (f_rgb),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .hi_x      (m_hi_x),
        .lo_x      (m_lo_x),
        .hi_y      (m_hi_y),
        .lo_y      (m_lo_y),
        .neg_x     (m_neg_x),
        .neg_y     (m_neg_y),
        .z         (m_z),
        .grid_col  (m_grid_col),
        .grid_row  (m_grid_row),
        .rgb       (m_rgb)
    );

    dpb_out #(
        .COORD_BITS (COORD_BITS)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (m_valid),
        .in_ready    (m_ready),
        .hi_x        (m_hi_x),
        .lo_x        (m_lo_x),
        .hi_y        (m_hi_y),
        .lo_y        (m_lo_y),
        .neg_x       (m_neg_x),
        .neg_y       (m_neg_y),
        .z_in        (m_z),
        .grid_col_in (m_grid_col),
        .grid_row_in (m_grid_row),
        .rgb_in      (m_rgb),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .grid_col    (grid_col),
        .grid_row    (grid_row),
        .rgb         (rgb_out)
    );

    assign m_axis_tdata = OUT_W'({rgb_out, grid_row, grid_col, point_z, point_y, point_x});

    // The input only stalls when every stage is full and the output is held
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the output side can move");

    // Depth in meters never passes ten meters
    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (point_z <= Z_W'(DEPTH_FULL - Z_HALF + 622592)))
        else $error("point_z above ten meters");

    // A point at zero depth sits at the origin
    a_zero_depth_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (point_z == '0)) |-> ((point_x == '0) && (point_y == '0)))
        else $error("zero depth point off the origin");

endmodule
